>>> sv/mtd_pkg.sv
package mtd_pkg;

  localparam int unsigned MaxMembersDef = 16;
  localparam int unsigned DefaultIntervalMsDef = 1000;
  localparam int unsigned IdW = 32;
  localparam int unsigned TimeW = 64;
  localparam int unsigned TmoW = 31;
  localparam int unsigned CountW = 5;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 32;

  typedef enum logic [1:0] {
    CMD_ADD    = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_TICK   = 2'd2,
    CMD_LOOKUP = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    KIND_RESP   = 2'd0,
    KIND_CHANGE = 2'd1,
    KIND_DONE   = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_PRESENT = 2'd1,
    STAT_FULL    = 2'd2,
    STAT_NOTFND  = 2'd3
  } status_e;

  localparam logic [1:0] HealthAlive   = 2'd0;
  localparam logic [1:0] HealthSuspect = 2'd1;
  localparam logic [1:0] HealthDead    = 2'd2;

  localparam logic [CfgIdxW-1:0] RegLocalId = 2'd0;
  localparam logic [CfgIdxW-1:0] RegSuspect = 2'd1;
  localparam logic [CfgIdxW-1:0] RegDead    = 2'd2;

  typedef struct packed {
    logic [1:0]       cmd;
    logic [IdW-1:0]   member_id;
    logic [TimeW-1:0] now_ms;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic [1:0]        status;
    logic [IdW-1:0]    report_id;
    logic [1:0]        prev_state;
    logic [1:0]        new_state;
    logic [CountW-1:0] member_count;
    logic              last;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SHIFT,
    ST_EMIT,
    ST_WAIT
  } ctrl_state_e;

  // Controller to datapath.
  typedef struct packed {
    logic load;      // capture input item, clear index
    logic step;      // advance walk index
    logic do_add;    // append new entry
    logic do_shift;  // copy entry idx+1 into idx
    logic dec_used;
    logic age;       // write aged health at idx
    logic set_found;
    logic emit;      // load output register
    logic emit_last;
    logic [1:0] emit_kind;
  } dp_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic [1:0] cmd;
    logic idx_end;    // idx at or past used
    logic shift_end;  // idx+1 at or past used
    logic match;      // entry at idx equals member_id
    logic full;
    logic found;
    logic changes;    // aging non-local entry at idx changes state
    logic out_busy;
  } dp_stat_t;

endpackage

>>> sv/mtd_ctrl.sv
module mtd_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  mtd_pkg::dp_stat_t stat_i,
  output mtd_pkg::dp_cmd_t  cmd_o
);
  import mtd_pkg::*;

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (stat_i.cmd == CMD_TICK) begin
          if (stat_i.idx_end) begin
            state_d = ST_WAIT;
          end else if (stat_i.changes) begin
            state_d = ST_EMIT;
          end
        end else if (stat_i.match && !stat_i.idx_end) begin
          if (stat_i.cmd == CMD_REMOVE) begin
            state_d = ST_SHIFT;
          end else begin
            state_d = ST_WAIT;
          end
        end else if (stat_i.idx_end) begin
          state_d = ST_WAIT;
        end
      end
      ST_SHIFT: begin
        if (stat_i.shift_end) begin
          state_d = ST_WAIT;
        end
      end
      ST_EMIT: begin
        if (!stat_i.out_busy) begin
          state_d = ST_SCAN;
        end
      end
      ST_WAIT: begin
        if (!stat_i.out_busy) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        cmd_o.load = in_valid_i;
      end
      ST_SCAN: begin
        if (stat_i.cmd == CMD_TICK) begin
          if (!stat_i.idx_end && !stat_i.changes) begin
            cmd_o.step = 1'b1;
          end
        end else if (stat_i.match && !stat_i.idx_end) begin
          cmd_o.set_found = 1'b1;
        end else if (!stat_i.idx_end) begin
          cmd_o.step = 1'b1;
        end else if (stat_i.cmd == CMD_ADD && !stat_i.full) begin
          cmd_o.do_add = 1'b1;
        end
      end
      ST_SHIFT: begin
        if (stat_i.shift_end) begin
          cmd_o.dec_used = 1'b1;
        end else begin
          cmd_o.do_shift = 1'b1;
          cmd_o.step     = 1'b1;
        end
      end
      ST_EMIT: begin
        if (!stat_i.out_busy) begin
          cmd_o.emit      = 1'b1;
          cmd_o.emit_kind = KIND_CHANGE;
          cmd_o.age       = 1'b1;
          cmd_o.step      = 1'b1;
        end
      end
      ST_WAIT: begin
        if (!stat_i.out_busy) begin
          cmd_o.emit      = 1'b1;
          cmd_o.emit_last = 1'b1;
          cmd_o.emit_kind = (stat_i.cmd == CMD_TICK) ? KIND_DONE : KIND_RESP;
        end
      end
      default: ;
    endcase
  end

endmodule

>>> sv/mtd_dp.sv
module mtd_dp #(
  parameter int unsigned MaxMembers        = mtd_pkg::MaxMembersDef,
  parameter int unsigned DefaultIntervalMs = mtd_pkg::DefaultIntervalMsDef
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  mtd_pkg::in_item_t                   in_data_i,
  input  logic                                cfg_we_i,
  input  logic [mtd_pkg::CfgIdxW-1:0]         cfg_index_i,
  input  logic [mtd_pkg::CfgDataW-1:0]        cfg_data_i,
  input  mtd_pkg::dp_cmd_t                    cmd_i,
  output mtd_pkg::dp_stat_t                   stat_o,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output mtd_pkg::out_item_t                  out_data_o
);
  import mtd_pkg::*;

  localparam int unsigned IdxW = $clog2(MaxMembers);
  localparam int unsigned UsedW = $clog2(MaxMembers + 1);
  localparam logic [TimeW-1:0] DefSus  = TimeW'(DefaultIntervalMs * 3);
  localparam logic [TimeW-1:0] DefDead = TimeW'(DefaultIntervalMs * 10);

  logic [IdW-1:0]   ids_q   [MaxMembers];
  logic [TimeW-1:0] seen_q  [MaxMembers];
  logic [1:0]       hlth_q  [MaxMembers];

  logic [UsedW-1:0] used_q;
  logic [UsedW-1:0] idx_q;
  logic             found_q;
  logic             added_q;
  logic [1:0]       fstate_q;
  in_item_t         item_q;
  logic [IdW-1:0]   local_q;
  logic [TmoW-1:0]  sus_q, dead_q;
  logic             oval_q;
  out_item_t        odat_q, odat_d;

  logic [IdxW-1:0]  idx;
  logic [IdxW-1:0]  idx1;
  logic [TimeW-1:0] elapsed, sus_lim, dead_lim;
  logic [1:0]       cur_h, aged_h;
  logic             is_local;

  assign idx      = idx_q[IdxW-1:0];
  assign idx1     = IdxW'(idx_q + 1'b1);
  assign cur_h    = hlth_q[idx];
  assign elapsed  = item_q.now_ms - seen_q[idx];
  assign sus_lim  = (sus_q == '0) ? DefSus : TimeW'(sus_q);
  assign dead_lim = (dead_q == '0) ? DefDead : TimeW'(dead_q);
  assign is_local = (ids_q[idx] == local_q);

  always_comb begin
    aged_h = cur_h;
    if (aged_h == HealthAlive && elapsed > sus_lim) begin
      aged_h = HealthSuspect;
    end
    if (aged_h == HealthSuspect && elapsed > dead_lim) begin
      aged_h = HealthDead;
    end
  end

  assign stat_o.cmd       = item_q.cmd;
  assign stat_o.idx_end   = (idx_q >= used_q);
  assign stat_o.shift_end = (UsedW'(idx_q + 1'b1) >= used_q);
  assign stat_o.match     = (ids_q[idx] == item_q.member_id);
  assign stat_o.full      = (used_q >= UsedW'(MaxMembers));
  assign stat_o.found     = found_q;
  assign stat_o.changes   = !is_local && (aged_h != cur_h);
  assign stat_o.out_busy  = oval_q && out_stall_i;

  // An add that was neither present nor appended found the table full.
  always_comb begin
    odat_d              = '0;
    odat_d.kind         = cmd_i.emit_kind;
    odat_d.last         = cmd_i.emit_last;
    odat_d.member_count = CountW'(used_q);
    odat_d.report_id    = item_q.member_id;
    odat_d.prev_state   = HealthAlive;
    odat_d.new_state    = HealthAlive;
    odat_d.status       = STAT_OK;
    if (cmd_i.emit_kind == KIND_CHANGE) begin
      odat_d.report_id  = ids_q[idx];
      odat_d.prev_state = cur_h;
      odat_d.new_state  = aged_h;
    end else if (cmd_i.emit_kind == KIND_DONE) begin
      odat_d.report_id = '0;
    end else begin
      unique case (item_q.cmd)
        CMD_ADD: begin
          if (found_q) begin
            odat_d.status = STAT_PRESENT;
          end else if (!added_q) begin
            odat_d.status = STAT_FULL;
          end
        end
        CMD_REMOVE: begin
          if (!found_q) begin
            odat_d.status = STAT_NOTFND;
          end else begin
            odat_d.prev_state = fstate_q;
          end
        end
        CMD_LOOKUP: begin
          if (!found_q) begin
            odat_d.status = STAT_NOTFND;
          end else begin
            odat_d.new_state = fstate_q;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.do_add) begin
      ids_q[idx]  <= item_q.member_id;
      seen_q[idx] <= item_q.now_ms;
      hlth_q[idx] <= HealthAlive;
    end else if (cmd_i.do_shift) begin
      ids_q[idx]  <= ids_q[idx1];
      seen_q[idx] <= seen_q[idx1];
      hlth_q[idx] <= hlth_q[idx1];
    end else if (cmd_i.age) begin
      hlth_q[idx] <= aged_h;
    end
    if (cmd_i.load) begin
      item_q <= in_data_i;
    end
    if (cmd_i.set_found) begin
      fstate_q <= cur_h;
    end
    if (cmd_i.emit) begin
      odat_q <= odat_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q  <= '0;
      idx_q   <= '0;
      found_q <= 1'b0;
      added_q <= 1'b0;
      local_q <= '0;
      sus_q   <= '0;
      dead_q  <= '0;
      oval_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          RegLocalId: local_q <= cfg_data_i;
          RegSuspect: sus_q   <= cfg_data_i[TmoW-1:0];
          RegDead:    dead_q  <= cfg_data_i[TmoW-1:0];
          default: ;
        endcase
      end
      if (cmd_i.load) begin
        idx_q   <= '0;
        found_q <= 1'b0;
        added_q <= 1'b0;
      end else if (cmd_i.step) begin
        idx_q <= idx_q + 1'b1;
      end
      if (cmd_i.set_found) begin
        found_q <= 1'b1;
      end
      if (cmd_i.do_add) begin
        used_q  <= used_q + 1'b1;
        added_q <= 1'b1;
      end
      if (cmd_i.dec_used) begin
        used_q <= used_q - 1'b1;
      end
      if (cmd_i.emit) begin
        oval_q <= 1'b1;
      end else if (!out_stall_i) begin
        oval_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = oval_q;
  assign out_data_o  = odat_q;

endmodule

>>> sv/membership_timeout_detector.sv
// Membership table with heartbeat timeouts, one item at a time.
// Add, remove and lookup walk (or shift) the table one entry per cycle and
// end with one response; the next item is taken in the same cycle that the
// response becomes valid. A tick sends a state-change report per changing
// entry, then a done item; a stalled output beat holds the walk.
// Reset (async, active low) empties the table.
module membership_timeout_detector #(
  parameter int unsigned MaxMembers        = mtd_pkg::MaxMembersDef,
  parameter int unsigned DefaultIntervalMs = mtd_pkg::DefaultIntervalMsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  mtd_pkg::in_item_t            in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output mtd_pkg::out_item_t           out_data_o,
  input  logic                         cfg_we_i,
  input  logic [mtd_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [mtd_pkg::CfgDataW-1:0] cfg_data_i
);
  import mtd_pkg::*;

  // The controller sequences the walk; the datapath holds the table.
  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  mtd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (dp_stat),
    .cmd_o      (dp_cmd)
  );

  mtd_dp #(
    .MaxMembers        (MaxMembers),
    .DefaultIntervalMs (DefaultIntervalMs)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (dp_cmd),
    .stat_o      (dp_stat),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
